@@ src/scrm_pkg.sv @@
// ----------------------------------------------------------------------------
// scrm_pkg: shared types and constants for the two-wire register master
// Item and result word layouts, request kind codes, register indexes,
// reset values and queue geometry.
// ----------------------------------------------------------------------------
package scrm_pkg;

	// Request kind codes on the input word
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IDX_W    = 1;
	localparam logic       CFG_DEV_ADDR = 1'b0;
	localparam logic       CFG_PHASE    = 1'b1;

	// Reset values and fixed bytes
	localparam logic [7:0]  DEV_ADDR_RST = 8'h42;
	localparam logic [15:0] PHASE_RST    = 16'd5;
	localparam logic [7:0]  READ_BIT     = 8'h01;
	localparam logic [7:0]  ABORT_DATA   = 8'hFF;

	// Depth of the queues between the parts (power of two)
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Classified input word
	typedef struct packed {
		logic       start;
		logic       rd;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	// Bus line levels
	typedef struct packed {
		logic scl;
		logic sda;
		logic en;
	} lines_t;

	// Result word
	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_enable;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

endpackage

@@ src/scrm_queue.sv @@
// ----------------------------------------------------------------------------
// scrm_queue: small first-in first-out buffer
// Register-based queue used between the front, the sequencer and the
// result port. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module scrm_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int CNT_W = scrm_pkg::QPTR_W + 1;

	logic [WIDTH-1:0]            mem_q [scrm_pkg::QDEPTH];
	logic [scrm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [scrm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (cnt_q == CNT_W'(scrm_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/scrm_front.sv @@
// ----------------------------------------------------------------------------
// scrm_front: input side of the register master
// Decodes the request kind of each incoming word and holds classified
// words in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module scrm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      kind,
	input  logic [7:0]      reg_addr,
	input  logic [7:0]      write_data,
	input  logic            sda_in,
	input  logic            take,
	output scrm_pkg::item_t item,
	output logic            item_empty
);

	scrm_pkg::item_t cls;

	// Classify: kind three counts as a plain tick
	always_comb begin
		cls.start      = (kind == scrm_pkg::KIND_WRITE) || (kind == scrm_pkg::KIND_READ);
		cls.rd         = (kind == scrm_pkg::KIND_READ);
		cls.reg_addr   = reg_addr;
		cls.write_data = write_data;
		cls.sda_in     = sda_in;
	end

	scrm_queue #(
		.WIDTH($bits(scrm_pkg::item_t))
	) u_in_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (take),
		.rdata (item),
		.empty (item_empty)
	);

endmodule

@@ src/scrm_seq.sv @@
// ----------------------------------------------------------------------------
// scrm_seq: bus sequencer of the register master
// Walks the start, byte, acknowledge, read and stop phases one tick per
// word taken, and emits one result word per tick. Holds the two
// configuration registers.
// ----------------------------------------------------------------------------
module scrm_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [scrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  scrm_pkg::item_t                item,
	input  logic                           take,
	output scrm_pkg::res_t                 res
);

	// Sequence steps
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_START_A  = 4'd1;
	localparam logic [3:0] ST_START_B  = 4'd2;
	localparam logic [3:0] ST_START_C  = 4'd3;
	localparam logic [3:0] ST_TX_SETUP = 4'd4;
	localparam logic [3:0] ST_TX_HIGH  = 4'd5;
	localparam logic [3:0] ST_TX_LOW   = 4'd6;
	localparam logic [3:0] ST_ACK_REL  = 4'd7;
	localparam logic [3:0] ST_ACK_HIGH = 4'd8;
	localparam logic [3:0] ST_RX_HIGH  = 4'd9;
	localparam logic [3:0] ST_RX_LOW   = 4'd10;
	localparam logic [3:0] ST_MN_SETUP = 4'd11;
	localparam logic [3:0] ST_MN_HIGH  = 4'd12;
	localparam logic [3:0] ST_STOP_A   = 4'd13;
	localparam logic [3:0] ST_STOP_B   = 4'd14;
	localparam logic [3:0] ST_STOP_C   = 4'd15;

	// Configuration registers
	logic [7:0]       dev_addr_q;
	logic [15:0]      phase_q;

	// Sequencer state
	logic [3:0]       step_q,  n_step;
	logic [15:0]      cnt_q,   n_cnt;
	logic [7:0]       shift_q, n_shift;
	logic [3:0]       bcnt_q,  n_bcnt;
	logic [1:0]       bidx_q,  n_bidx;
	logic             rd_q,    n_rd;
	logic [15:0]      saved_q, n_saved;
	logic             err_q,   n_err;
	logic [7:0]       rres_q,  n_rres;
	scrm_pkg::lines_t lines_q, n_lines;

	logic             ent;
	logic [3:0]       ent_step;
	logic             done;
	logic [15:0]      limit;
	logic [15:0]      cnt_inc;

	// Line levels shown in each phase
	function automatic scrm_pkg::lines_t lines_for(logic [3:0] st, logic bit_v, logic keep);
		scrm_pkg::lines_t l;
		unique case (st)
			ST_START_A:  l = '{scl: 1'b1, sda: 1'b1,  en: 1'b1};
			ST_START_B:  l = '{scl: 1'b1, sda: 1'b0,  en: 1'b1};
			ST_START_C:  l = '{scl: 1'b0, sda: 1'b0,  en: 1'b1};
			ST_TX_SETUP: l = '{scl: 1'b0, sda: bit_v, en: 1'b1};
			ST_TX_HIGH:  l = '{scl: 1'b1, sda: bit_v, en: 1'b1};
			ST_TX_LOW:   l = '{scl: 1'b0, sda: bit_v, en: 1'b1};
			ST_ACK_REL:  l = '{scl: 1'b0, sda: keep,  en: 1'b0};
			ST_ACK_HIGH: l = '{scl: 1'b1, sda: keep,  en: 1'b0};
			ST_RX_HIGH:  l = '{scl: 1'b1, sda: keep,  en: 1'b0};
			ST_RX_LOW:   l = '{scl: 1'b0, sda: keep,  en: 1'b0};
			ST_MN_SETUP: l = '{scl: 1'b0, sda: 1'b1,  en: 1'b1};
			ST_MN_HIGH:  l = '{scl: 1'b1, sda: 1'b1,  en: 1'b1};
			ST_STOP_A:   l = '{scl: 1'b0, sda: 1'b0,  en: 1'b1};
			ST_STOP_B:   l = '{scl: 1'b1, sda: 1'b0,  en: 1'b1};
			ST_STOP_C:   l = '{scl: 1'b1, sda: 1'b1,  en: 1'b1};
			default:     l = '{scl: 1'b1, sda: 1'b1,  en: 1'b1};
		endcase
		return l;
	endfunction

	// Work out the next state for this tick
	always_comb begin
		n_step   = step_q;
		n_cnt    = cnt_q;
		n_shift  = shift_q;
		n_bcnt   = bcnt_q;
		n_bidx   = bidx_q;
		n_rd     = rd_q;
		n_saved  = saved_q;
		n_err    = err_q;
		n_rres   = rres_q;
		n_lines  = lines_q;
		ent      = 1'b0;
		ent_step = ST_IDLE;
		done     = 1'b0;
		limit    = (phase_q == 16'd0) ? 16'd1 : phase_q;
		cnt_inc  = cnt_q + 16'd1;

		if (step_q == ST_IDLE) begin
			// Start a transaction on a request
			if (item.start) begin
				n_rd     = item.rd;
				n_saved  = {(item.rd ? 8'h00 : item.write_data), item.reg_addr};
				n_err    = 1'b0;
				n_bidx   = 2'd0;
				n_bcnt   = 4'd0;
				n_shift  = dev_addr_q;
				ent      = 1'b1;
				ent_step = ST_START_A;
			end
		end else begin
			n_cnt = cnt_inc;
			// End of phase: move to the next one
			if (cnt_inc >= limit) begin
				unique case (step_q)
					ST_START_A: begin
						ent = 1'b1; ent_step = ST_START_B;
					end
					ST_START_B: begin
						ent = 1'b1; ent_step = ST_START_C;
					end
					ST_START_C: begin
						n_bcnt = 4'd0;
						ent = 1'b1; ent_step = ST_TX_SETUP;
					end
					ST_TX_SETUP: begin
						ent = 1'b1; ent_step = ST_TX_HIGH;
					end
					ST_TX_HIGH: begin
						ent = 1'b1; ent_step = ST_TX_LOW;
					end
					ST_TX_LOW: begin
						n_shift  = {shift_q[6:0], 1'b0};
						n_bcnt   = bcnt_q + 4'd1;
						ent      = 1'b1;
						ent_step = (n_bcnt >= 4'd8) ? ST_ACK_REL : ST_TX_SETUP;
					end
					ST_ACK_REL: begin
						ent = 1'b1; ent_step = ST_ACK_HIGH;
					end
					ST_ACK_HIGH: begin
						if (rd_q && item.sda_in) begin
							// NACK in a read: abort with stop
							n_err    = 1'b1;
							n_rres   = scrm_pkg::ABORT_DATA;
							n_bidx   = 2'd3;
							ent      = 1'b1;
							ent_step = ST_STOP_A;
						end else begin
							if (item.sda_in) begin
								n_err = 1'b1;
							end
							ent = 1'b1;
							unique case (bidx_q)
								2'd0: begin
									n_bidx   = 2'd1;
									n_shift  = saved_q[7:0];
									n_bcnt   = 4'd0;
									ent_step = ST_TX_SETUP;
								end
								2'd1: begin
									n_bidx = 2'd2;
									if (rd_q) begin
										ent_step = ST_STOP_A;
									end else begin
										n_shift  = saved_q[15:8];
										n_bcnt   = 4'd0;
										ent_step = ST_TX_SETUP;
									end
								end
								default: begin
									if (rd_q) begin
										n_shift  = 8'h00;
										n_bcnt   = 4'd0;
										ent_step = ST_RX_HIGH;
									end else begin
										n_bidx   = 2'd3;
										ent_step = ST_STOP_A;
									end
								end
							endcase
						end
					end
					ST_RX_HIGH: begin
						n_shift = {shift_q[6:0], item.sda_in};
						ent = 1'b1; ent_step = ST_RX_LOW;
					end
					ST_RX_LOW: begin
						n_bcnt = bcnt_q + 4'd1;
						ent    = 1'b1;
						if (n_bcnt >= 4'd8) begin
							n_rres   = shift_q;
							n_bidx   = 2'd3;
							ent_step = ST_MN_SETUP;
						end else begin
							ent_step = ST_RX_HIGH;
						end
					end
					ST_MN_SETUP: begin
						ent = 1'b1; ent_step = ST_MN_HIGH;
					end
					ST_MN_HIGH: begin
						ent = 1'b1; ent_step = ST_STOP_A;
					end
					ST_STOP_A: begin
						ent = 1'b1; ent_step = ST_STOP_B;
					end
					ST_STOP_B: begin
						ent = 1'b1; ent_step = ST_STOP_C;
					end
					ST_STOP_C: begin
						if (bidx_q == 2'd2) begin
							// Restart with the read address
							n_shift  = dev_addr_q | scrm_pkg::READ_BIT;
							ent      = 1'b1;
							ent_step = ST_START_A;
						end else begin
							n_step = ST_IDLE;
							n_cnt  = 16'd0;
							done   = 1'b1;
						end
					end
					default: begin
						n_step = ST_IDLE;
					end
				endcase
			end
		end

		// Enter the new phase
		if (ent) begin
			n_step  = ent_step;
			n_cnt   = 16'd0;
			n_lines = lines_for(ent_step, n_shift[7], lines_q.sda);
		end
	end

	// Build the result word from the updated state
	always_comb begin
		res.scl        = n_lines.scl;
		res.sda_out    = n_lines.sda;
		res.sda_enable = n_lines.en;
		res.busy       = (n_step != ST_IDLE);
		res.done       = done;
		res.read_data  = n_rres;
		res.ack_error  = n_err;
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= scrm_pkg::DEV_ADDR_RST;
			phase_q    <= scrm_pkg::PHASE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				scrm_pkg::CFG_DEV_ADDR: dev_addr_q <= cfg_data[7:0];
				scrm_pkg::CFG_PHASE:    phase_q    <= cfg_data;
				default:                phase_q    <= phase_q;
			endcase
		end
	end

	// Advance the sequencer on each word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			bcnt_q  <= '0;
			bidx_q  <= '0;
			rd_q    <= 1'b0;
			saved_q <= '0;
			err_q   <= 1'b0;
			rres_q  <= scrm_pkg::ABORT_DATA;
			lines_q <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
		end else if (take) begin
			step_q  <= n_step;
			cnt_q   <= n_cnt;
			shift_q <= n_shift;
			bcnt_q  <= n_bcnt;
			bidx_q  <= n_bidx;
			rd_q    <= n_rd;
			saved_q <= n_saved;
			err_q   <= n_err;
			rres_q  <= n_rres;
			lines_q <= n_lines;
		end
	end

endmodule

@@ src/sccb_register_master_top.sv @@
// ----------------------------------------------------------------------------
// sccb_register_master_top: two-wire register-access master
// Channel  | Handshake              | Word
// ---------+------------------------+----------------------------------------
// input    | push / full            | kind, reg_addr, write_data, sda_in
// result   | pop / empty            | scl, sda_out, sda_enable, busy_res,
//          |                        | done_res, read_data, ack_error
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One tick word per clock sustained while the result queue has room; the
// sequencer advances one bus tick per cycle while it takes words, and each
// word gives one result word. The sequencer takes a word only when one
// waits and the result queue has room; full rises when two tick words wait
// for the sequencer. Reset is asynchronous: idle bus with SCL and SDA
// driven high, device address 0x42, five ticks per phase. No clearing pass.
// ----------------------------------------------------------------------------
module sccb_register_master_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     reg_addr,
	input  logic [7:0]                     write_data,
	input  logic                           sda_in,
	// result words
	output logic                           empty,
	input  logic                           pop,
	output logic                           scl,
	output logic                           sda_out,
	output logic                           sda_enable,
	output logic                           busy_res,
	output logic                           done_res,
	output logic [7:0]                     read_data,
	output logic                           ack_error,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	scrm_pkg::item_t item;
	scrm_pkg::res_t  res;
	scrm_pkg::res_t  res_head;
	logic            item_empty;
	logic            res_full;
	logic            take;

	assign cfg_ready = 1'b1;

	// Take a tick word when one waits and the result queue has room
	assign take = !item_empty && !res_full;

	scrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.sda_in    (sda_in),
		.take      (take),
		.item      (item),
		.item_empty(item_empty)
	);

	scrm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.take     (take),
		.res      (res)
	);

	scrm_queue #(
		.WIDTH($bits(scrm_pkg::res_t))
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	// Drive result ports from the queue head
	assign scl        = res_head.scl;
	assign sda_out    = res_head.sda_out;
	assign sda_enable = res_head.sda_enable;
	assign busy_res   = res_head.busy;
	assign done_res   = res_head.done;
	assign read_data  = res_head.read_data;
	assign ack_error  = res_head.ack_error;

`ifndef NO_ASSERTIONS
	// A completing tick is never shown as busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> !busy_res)
		else $error("done shown while busy");

	// An idle bus leaves both lines driven high
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !busy_res) |-> (scl && sda_out && sda_enable))
		else $error("idle bus lines not high");

	// The sequencer never writes into a full result queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!res_full && !item_empty))
		else $error("sequencer step without room");
`endif

endmodule

@@ dv/sccb_master_checker.sv @@
// ----------------------------------------------------------------------------
// sccb_master_checker: bus sequence predictor and result comparator
// Follows every accepted tick word and configuration write, works out the
// bus levels and status that each tick must produce, and compares them
// field by field with the result words as they are popped.
// ----------------------------------------------------------------------------
module sccb_master_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     reg_addr,
	input  logic [7:0]                     write_data,
	input  logic                           sda_in,
	input  logic                           empty,
	input  logic                           pop,
	input  logic                           scl,
	input  logic                           sda_out,
	input  logic                           sda_enable,
	input  logic                           busy_res,
	input  logic                           done_res,
	input  logic [7:0]                     read_data,
	input  logic                           ack_error,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [scrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output int                             outstanding,
	output int                             fail_count
);
	import scrm_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef enum logic [4:0] {
		SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_START_C,
		SEQ_TX_SETUP, SEQ_TX_HIGH, SEQ_TX_LOW, SEQ_ACK_REL, SEQ_ACK_HIGH,
		SEQ_RX_HIGH, SEQ_RX_LOW, SEQ_MN_SETUP, SEQ_MN_HIGH,
		SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C
	} seq_step_e;

	// Register copies
	logic [7:0]  dev_addr;
	logic [15:0] phase_len;

	// Sequencer copy
	seq_step_e   step;
	logic [15:0] phase_cnt;
	logic [7:0]  shifter;
	logic [3:0]  bit_cnt;
	logic [1:0]  byte_no;
	logic        rd_txn;
	logic [15:0] saved_bytes;
	logic        nack_seen;
	logic [7:0]  last_read;
	lines_t      lines;

	res_t        expected_words[$];
	res_t        want;
	int          result_no;

	function void drive_lines(logic c, logic d, logic e);
		lines.scl = c;
		lines.sda = d;
		lines.en  = e;
	endfunction

	// Enter a bus phase and show its line levels
	function void enter_step(seq_step_e s);
		logic data_bit;
		logic held;
		data_bit  = shifter[7];
		held      = lines.sda;
		step      = s;
		phase_cnt = '0;
		case (s)
			SEQ_START_A:  drive_lines(1'b1, 1'b1, 1'b1);
			SEQ_START_B:  drive_lines(1'b1, 1'b0, 1'b1);
			SEQ_START_C:  drive_lines(1'b0, 1'b0, 1'b1);
			SEQ_TX_SETUP: drive_lines(1'b0, data_bit, 1'b1);
			SEQ_TX_HIGH:  drive_lines(1'b1, data_bit, 1'b1);
			SEQ_TX_LOW:   drive_lines(1'b0, data_bit, 1'b1);
			SEQ_ACK_REL:  drive_lines(1'b0, held, 1'b0);
			SEQ_ACK_HIGH: drive_lines(1'b1, held, 1'b0);
			SEQ_RX_HIGH:  drive_lines(1'b1, held, 1'b0);
			SEQ_RX_LOW:   drive_lines(1'b0, held, 1'b0);
			SEQ_MN_SETUP: drive_lines(1'b0, 1'b1, 1'b1);
			SEQ_MN_HIGH:  drive_lines(1'b1, 1'b1, 1'b1);
			SEQ_STOP_A:   drive_lines(1'b0, 1'b0, 1'b1);
			SEQ_STOP_B:   drive_lines(1'b1, 1'b0, 1'b1);
			SEQ_STOP_C:   drive_lines(1'b1, 1'b1, 1'b1);
			default: ;
		endcase
	endfunction

	function void load_byte(logic [7:0] b);
		shifter = b;
		bit_cnt = '0;
		enter_step(SEQ_TX_SETUP);
	endfunction

	// Decide what follows an acknowledge slot
	function void ack_slot_end(logic nack);
		if (rd_txn && nack) begin
			// a read gives up at once on any NACK
			nack_seen = 1'b1;
			last_read = ABORT_DATA;
			byte_no   = 2'd3;
			enter_step(SEQ_STOP_A);
		end else begin
			if (nack)
				nack_seen = 1'b1;
			case (byte_no)
				2'd0: begin
					byte_no = 2'd1;
					load_byte(saved_bytes[7:0]);
				end
				2'd1: begin
					byte_no = 2'd2;
					if (rd_txn)
						enter_step(SEQ_STOP_A);
					else
						load_byte(saved_bytes[15:8]);
				end
				default: begin
					if (rd_txn) begin
						shifter = '0;
						bit_cnt = '0;
						enter_step(SEQ_RX_HIGH);
					end else begin
						byte_no = 2'd3;
						enter_step(SEQ_STOP_A);
					end
				end
			endcase
		end
	endfunction

	// Close the current phase; high when the transaction completes
	function logic end_phase(logic sda);
		case (step)
			SEQ_START_A:  enter_step(SEQ_START_B);
			SEQ_START_B:  enter_step(SEQ_START_C);
			SEQ_START_C: begin
				bit_cnt = '0;
				enter_step(SEQ_TX_SETUP);
			end
			SEQ_TX_SETUP: enter_step(SEQ_TX_HIGH);
			SEQ_TX_HIGH:  enter_step(SEQ_TX_LOW);
			SEQ_TX_LOW: begin
				shifter = {shifter[6:0], 1'b0};
				bit_cnt = bit_cnt + 4'd1;
				enter_step(bit_cnt >= 4'd8 ? SEQ_ACK_REL : SEQ_TX_SETUP);
			end
			SEQ_ACK_REL:  enter_step(SEQ_ACK_HIGH);
			SEQ_ACK_HIGH: ack_slot_end(sda);
			SEQ_RX_HIGH: begin
				shifter = {shifter[6:0], sda};
				enter_step(SEQ_RX_LOW);
			end
			SEQ_RX_LOW: begin
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8) begin
					last_read = shifter;
					byte_no   = 2'd3;
					enter_step(SEQ_MN_SETUP);
				end else begin
					enter_step(SEQ_RX_HIGH);
				end
			end
			SEQ_MN_SETUP: enter_step(SEQ_MN_HIGH);
			SEQ_MN_HIGH:  enter_step(SEQ_STOP_A);
			SEQ_STOP_A:   enter_step(SEQ_STOP_B);
			SEQ_STOP_B:   enter_step(SEQ_STOP_C);
			SEQ_STOP_C: begin
				if (byte_no == 2'd2) begin
					// restart with the read address as it stands now
					shifter = dev_addr | READ_BIT;
					enter_step(SEQ_START_A);
				end else begin
					step      = SEQ_IDLE;
					phase_cnt = '0;
					return 1'b1;
				end
			end
			default: step = SEQ_IDLE;
		endcase
		return 1'b0;
	endfunction

	// Advance the sequencer by one tick and build the word it shows
	function res_t bus_tick(logic [1:0] k, logic [7:0] ra, logic [7:0] wd, logic sda);
		res_t        w;
		logic        fin;
		logic [15:0] lim;
		fin = 1'b0;
		if (step == SEQ_IDLE) begin
			if (k == KIND_WRITE || k == KIND_READ) begin
				rd_txn      = (k == KIND_READ);
				saved_bytes = {rd_txn ? 8'h00 : wd, ra};
				nack_seen   = 1'b0;
				byte_no     = '0;
				bit_cnt     = '0;
				shifter     = dev_addr;
				enter_step(SEQ_START_A);
			end
		end else begin
			// zero ticks per phase behaves as one
			lim       = (phase_len == 16'd0) ? 16'd1 : phase_len;
			phase_cnt = phase_cnt + 16'd1;
			if (phase_cnt >= lim)
				fin = end_phase(sda);
		end
		w.scl        = lines.scl;
		w.sda_out    = lines.sda;
		w.sda_enable = lines.en;
		w.busy       = (step != SEQ_IDLE);
		w.done       = fin;
		w.read_data  = last_read;
		w.ack_error  = nack_seen;
		return w;
	endfunction

	function void reset_model();
		dev_addr    = DEV_ADDR_RST;
		phase_len   = PHASE_RST;
		step        = SEQ_IDLE;
		phase_cnt   = '0;
		shifter     = '0;
		bit_cnt     = '0;
		byte_no     = '0;
		rd_txn      = 1'b0;
		saved_bytes = '0;
		nack_seen   = 1'b0;
		last_read   = ABORT_DATA;
		drive_lines(1'b1, 1'b1, 1'b1);
	endfunction

	task report_mismatch(string what);
		if (fail_count < PRINT_CAP)
			$display("[%0t] result %0d: %s", $time, result_no, what);
		fail_count++;
	endtask

	task check_field(string name, logic [7:0] got, logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s is %0h, should be %0h", name, got, exp_val));
	endtask

	initial begin
		fail_count  = 0;
		outstanding = 0;
		result_no   = 0;
	end

	// Track configuration, compare popped words, predict pushed words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_words.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DEV_ADDR)
					dev_addr = cfg_data[7:0];
				else
					phase_len = cfg_data;
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					check_field("scl", 8'(scl), 8'(want.scl));
					check_field("sda_out", 8'(sda_out), 8'(want.sda_out));
					check_field("sda_enable", 8'(sda_enable), 8'(want.sda_enable));
					check_field("busy_res", 8'(busy_res), 8'(want.busy));
					check_field("done_res", 8'(done_res), 8'(want.done));
					check_field("read_data", read_data, want.read_data);
					check_field("ack_error", 8'(ack_error), 8'(want.ack_error));
				end
				result_no++;
			end
			if (push && !full)
				expected_words.push_back(bus_tick(kind, reg_addr, write_data, sda_in));
			outstanding = expected_words.size();
		end
	end

endmodule

@@ dv/sccb_register_master_top_test.sv @@
// ----------------------------------------------------------------------------
// sccb_register_master_top_test: stimulus and verdict for the register master
// Drives tick words shaped as whole register writes and reads, with planned
// ACK/NACK slots and read bytes, under several bus timings and device
// addresses; the checker beside the block predicts and compares each word.
// ----------------------------------------------------------------------------
module sccb_register_master_top_test;
	import scrm_pkg::*;

	localparam int        PERIOD       = 10;
	localparam int        RESET_CYCLES = 11;
	localparam int        LIMIT_CYCLES = 400000;
	localparam int        RANDOM_ITEMS = 1400;
	localparam int        CALM_ITEMS   = 250;
	localparam int        LONG_HOLD    = 300;
	localparam int        SETTLE       = 4;
	localparam int        TAIL_CYCLES  = 20;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	// Bus phase numbers (counted from the first start phase) that matter
	localparam int ACK_ADDR_PHASE  = 28;
	localparam int ACK_REG_PHASE   = 54;
	localparam int ACK_WDATA_PHASE = 80;
	localparam int ACK_RADDR_PHASE = 86;
	localparam int RX_FIRST_PHASE  = 87;
	localparam int RX_LAST_PHASE   = 101;
	localparam int WRITE_PHASES    = 84;
	localparam int READ_PHASES     = 108;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [1:0]           kind;
	logic [7:0]           reg_addr;
	logic [7:0]           write_data;
	logic                 sda_in;
	logic                 empty;
	logic                 pop;
	logic                 scl;
	logic                 sda_out;
	logic                 sda_enable;
	logic                 busy_res;
	logic                 done_res;
	logic [7:0]           read_data;
	logic                 ack_error;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	int                   outstanding;
	int                   fail_count;

	// Transaction plan
	logic [1:0] plan_kind;
	logic [7:0] plan_reg;
	logic [7:0] plan_data;
	logic [7:0] plan_byte;
	logic [2:0] plan_nack;
	int         plan_tpp;
	int         plan_shift;
	int         plan_len;

	int cur_tpp    = PHASE_RST;
	int gap_odds   = 6;
	int noise_odds = 12;
	int items_sent = 0;
	int cycle_no   = 0;
	bit long_hold  = 1'b0;

	sccb_register_master_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.sda_in     (sda_in),
		.empty      (empty),
		.pop        (pop),
		.scl        (scl),
		.sda_out    (sda_out),
		.sda_enable (sda_enable),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.ack_error  (ack_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	sccb_master_checker bus_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.reg_addr    (reg_addr),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.empty       (empty),
		.pop         (pop),
		.scl         (scl),
		.sda_out     (sda_out),
		.sda_enable  (sda_enable),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data),
		.ack_error   (ack_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drain results; stall in random bursts and for a long stretch on request
	initial begin
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold  = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && gap_odds != 0 &&
					$urandom_range(1, gap_odds) == 1) begin
				stall_left = $urandom_range(1, 12);
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offer one tick word and hold it until taken
	task send_item(logic [1:0] k, logic [7:0] ra, logic [7:0] wd, logic s);
		int gap;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 12);
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push       <= 1'b1;
		kind       <= k;
		reg_addr   <= ra;
		write_data <= wd;
		sda_in     <= s;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait for every expected word
	task drain();
		@(negedge clk) push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk) cfg_valid <= 1'b0;
		if (idx == CFG_PHASE)
			cur_tpp = (val == 16'd0) ? 1 : int'(val);
	endtask

	task plan_txn(logic [1:0] k, logic [7:0] ra, logic [7:0] wd, logic [2:0] nacks,
			logic [7:0] rb);
		plan_kind  = k;
		plan_reg   = ra;
		plan_data  = wd;
		plan_nack  = nacks;
		plan_byte  = rb;
		plan_tpp   = cur_tpp;
		plan_shift = 0;
		plan_len   = (k == KIND_READ ? READ_PHASES : WRITE_PHASES) * cur_tpp;
	endtask

	// SDA level for tick t of the plan: ack slots and read bits as planned
	function logic slot_level(int t);
		int rel;
		int k;
		rel = t - plan_shift;
		if (rel > 0 && rel % plan_tpp == 0) begin
			k = rel / plan_tpp - 1;
			if (k == ACK_ADDR_PHASE)
				return plan_nack[0];
			if (k == ACK_REG_PHASE)
				return plan_nack[1];
			if (k == (plan_kind == KIND_READ ? ACK_RADDR_PHASE : ACK_WDATA_PHASE))
				return plan_nack[2];
			if (plan_kind == KIND_READ && k >= RX_FIRST_PHASE && k <= RX_LAST_PHASE &&
					(k - RX_FIRST_PHASE) % 2 == 0)
				return plan_byte[7 - (k - RX_FIRST_PHASE) / 2];
		end
		return $urandom_range(0, 1) != 0;
	endfunction

	// Send ticks first..last of the plan, with stray words mixed in
	task run_span(int first, int last);
		logic [1:0] k;
		for (int t = first; t <= last; t++) begin
			if (t == 0)
				k = plan_kind;
			else if (t > plan_len + plan_shift)
				k = ($urandom_range(0, 1) != 0) ? KIND_TICK : KIND_SPARE;
			else if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
				k = 2'($urandom_range(0, 3));
			else
				k = KIND_TICK;
			if (t == 0)
				send_item(k, plan_reg, plan_data, slot_level(t));
			else
				send_item(k, 8'($urandom), 8'($urandom), slot_level(t));
		end
	endtask

	task run_txn(logic [1:0] k, logic [7:0] ra, logic [7:0] wd, logic [2:0] nacks,
			logic [7:0] rb);
		plan_txn(k, ra, wd, nacks, rb);
		run_span(0, plan_len + $urandom_range(1, 4));
	endtask

	initial begin
		int         random_start;
		int         txn_no;
		logic [2:0] nacks;
		arst_n     = 1'b0;
		push       = 1'b0;
		kind       = KIND_TICK;
		reg_addr   = '0;
		write_data = '0;
		sda_in     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_DEV_ADDR;
		cfg_data   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings; requests and spare kinds arrive while busy
		noise_odds = 4;
		run_txn(KIND_WRITE, 8'hFF, 8'h00, 3'b000, 8'h00);
		noise_odds = 12;

		// Fastest timing: clean reads at both byte extremes, NACK paths
		drain();
		write_reg(CFG_PHASE, 16'd1);
		run_txn(KIND_READ, 8'h00, 8'h00, 3'b000, 8'hFF);
		run_txn(KIND_READ, 8'hFF, 8'hFF, 3'b000, 8'h00);
		run_txn(KIND_WRITE, 8'h00, 8'hFF, 3'b111, 8'h00);
		run_txn(KIND_WRITE, 8'h5A, 8'hA5, 3'b100, 8'h00);
		run_txn(KIND_READ, 8'h33, 8'h00, 3'b001, 8'h55);
		run_txn(KIND_READ, 8'hCC, 8'h00, 3'b010, 8'hAA);
		run_txn(KIND_READ, 8'h0F, 8'h00, 3'b100, 8'h5A);

		// Device address extremes
		drain();
		write_reg(CFG_DEV_ADDR, 16'h00FF);
		run_txn(KIND_READ, 8'h3C, 8'h00, 3'b000, 8'h96);
		drain();
		write_reg(CFG_DEV_ADDR, 16'h0000);
		run_txn(KIND_WRITE, 8'hC3, 8'h69, 3'b000, 8'h00);

		// Zero ticks per phase runs as one
		drain();
		write_reg(CFG_PHASE, 16'd0);
		run_txn(KIND_READ, 8'h7E, 8'h00, 3'b000, 8'h81);

		// Longest phase holds the start; shorten it mid-transaction
		drain();
		write_reg(CFG_PHASE, 16'hFFFF);
		plan_txn(KIND_READ, 8'h81, 8'h00, 3'b000, 8'h7E);
		run_span(0, 200);
		drain();
		write_reg(CFG_PHASE, 16'd1);
		plan_txn(KIND_READ, 8'h81, 8'h00, 3'b000, 8'h7E);
		plan_shift = 200;
		run_span(201, 200 + plan_len + 3);

		// Device address changes during the register byte, before the restart
		drain();
		write_reg(CFG_DEV_ADDR, 16'(DEV_ADDR_RST));
		plan_txn(KIND_READ, 8'h10, 8'h00, 3'b000, 8'hC3);
		run_span(0, 40);
		drain();
		write_reg(CFG_DEV_ADDR, 16'h005A);
		run_span(41, plan_len + 2);

		// Random transactions, mostly well formed
		noise_odds   = 20;
		random_start = items_sent;
		txn_no       = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start > RANDOM_ITEMS - CALM_ITEMS) begin
				gap_odds = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: gap_odds = 0;
					1: gap_odds = 3;
					2: gap_odds = 8;
					default: gap_odds = 20;
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				drain();
				if ($urandom_range(0, 1) != 0)
					write_reg(CFG_DEV_ADDR, 16'($urandom_range(0, 255)));
				else if ($urandom_range(0, 2) == 0)
					write_reg(CFG_PHASE, 16'($urandom_range(0, 3)));
				else
					write_reg(CFG_PHASE, 16'd1);
			end
			// fill the block while results are held back
			if (txn_no == 2 || txn_no == 7)
				long_hold = 1'b1;
			nacks = ($urandom_range(0, 9) < 7) ? 3'b000 : 3'($urandom_range(1, 7));
			run_txn(($urandom_range(0, 1) != 0) ? KIND_READ : KIND_WRITE,
				8'($urandom), 8'($urandom), nacks, 8'($urandom));
			txn_no++;
		end

		gap_odds = 0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
src/scrm_pkg.sv
src/scrm_queue.sv
src/scrm_front.sv
src/scrm_seq.sv
src/sccb_register_master_top.sv
dv/sccb_master_checker.sv
dv/sccb_register_master_top_test.sv
